/* rtl/lkpm_pkg.sv */
// ----------------------------------------------------------------------------
// lkpm_pkg
// Types, codes and character helpers shared by the keyword prefix matcher.
// ----------------------------------------------------------------------------
package lkpm_pkg;

  localparam int LEN_W = 6;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_MATCH   = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic [LEN_W-1:0] match_length;
    logic [LEN_W-1:0] longest_keyword;
    logic [1:0]       status;
  } out_item_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Letters, digits and underscore; the argument is already folded.
  function automatic logic is_symbol(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
  endfunction

endpackage

/* rtl/longest_keyword_prefix_matcher.sv */
// ----------------------------------------------------------------------------
// longest_keyword_prefix_matcher
// Case-folded keyword table with longest-prefix match at a symbol boundary.
// ----------------------------------------------------------------------------
// Items arrive on the in_ channel (valid/stall) as clear, load or match
// commands. Clear and load items are handled in the idle state. A match
// character scans every stored keyword: one keyword-store read per stored
// keyword, through the single read port of the keyword memory. Once the
// string is dead, remaining characters skip the scan and go straight to
// the final state. The match item that carries last produces one result
// transfer on the out_ channel; all other items produce none.
// in_stall is high while an item is being worked on. A result sits in the
// output register until the receiver takes it; a following item is still
// accepted, but a further result waits in the final state until the output
// register is free, holding in_stall high meanwhile.
// Reset empties the table, clears the load status and restarts matching;
// the keyword memories need no clearing pass, since only committed entries
// are ever read.
// ----------------------------------------------------------------------------
module longest_keyword_prefix_matcher #(
  parameter int NUM_KEYWORDS    = 256,
  parameter int MAX_KEYWORD_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lkpm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lkpm_pkg::out_item_t  out_data
);

  localparam int KW  = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int KCW = $clog2(NUM_KEYWORDS + 1);
  localparam int AW  = (NUM_KEYWORDS * MAX_KEYWORD_LEN > 1) ?
                       $clog2(NUM_KEYWORDS * MAX_KEYWORD_LEN) : 1;
  localparam int LW  = lkpm_pkg::LEN_W;
  localparam logic [LW-1:0]  MAX_LEN = LW'(MAX_KEYWORD_LEN);
  localparam logic [KCW-1:0] NUM_KW  = KCW'(NUM_KEYWORDS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t state_r;

  logic [7:0]  kw_store [NUM_KEYWORDS*MAX_KEYWORD_LEN];
  logic [LW-1:0] kw_len [NUM_KEYWORDS];
  logic [NUM_KEYWORDS-1:0] alive_r;

  logic [KCW-1:0] count_r;
  logic [LW-1:0]  load_pos_r, longest_r, match_pos_r, best_r;
  logic           load_ovf_r, dead_r;
  logic [1:0]     load_err_r;

  logic [7:0]     char_r;
  logic           last_r;
  logic [KCW-1:0] issue_r;
  logic           eval_v_r;
  logic [KW-1:0]  eval_k_r;
  logic [7:0]     store_q_r;
  logic [LW-1:0]  len_q_r;
  logic           cond_a_r, cond_b_r, any_r;

  logic           out_valid_r;
  lkpm_pkg::out_item_t out_r;

  logic [7:0]  in_char;
  logic        in_acc, out_acc;
  logic        st_we, len_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [KW-1:0] kw_widx;
  logic [LW-1:0] commit_len;
  logic        scan_rd;
  logic        keep;
  logic [LW-1:0] best_nxt;
  logic        res_load;

  assign in_char  = lkpm_pkg::fold(in_data.character);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The final state reloads the output register in this cycle.
  assign res_load = (state_r == S_FIN) && last_r && (!out_valid_r || out_acc);

  // Keyword loading happens in the idle state only.
  assign kw_widx    = count_r[KW-1:0];
  assign st_we      = in_acc && in_data.command == lkpm_pkg::CMD_LOAD &&
                      load_pos_r < MAX_LEN && count_r < NUM_KW;
  assign st_waddr   = AW'(kw_widx) * AW'(MAX_KEYWORD_LEN) + AW'(load_pos_r);
  assign commit_len = (load_pos_r < MAX_LEN) ? load_pos_r + 1'b1 : load_pos_r;
  assign len_we     = in_acc && in_data.command == lkpm_pkg::CMD_LOAD && in_data.last &&
                      !(load_ovf_r || load_pos_r >= MAX_LEN) && count_r < NUM_KW;

  assign scan_rd  = (state_r == S_SCAN) && (issue_r < count_r);
  assign st_raddr = AW'(issue_r[KW-1:0]) * AW'(MAX_KEYWORD_LEN) + AW'(match_pos_r);

  always_ff @(posedge clk) begin
    if (st_we) begin
      kw_store[st_waddr] <= in_char;
    end
    if (len_we) begin
      kw_len[kw_widx] <= commit_len;
    end
    if (scan_rd) begin
      len_q_r <= kw_len[issue_r[KW-1:0]];
      if (match_pos_r < MAX_LEN) begin
        store_q_r <= kw_store[st_raddr];
      end
    end
  end

  // Survival of the keyword whose data has just been read.
  assign keep = alive_r[eval_k_r] && len_q_r > match_pos_r && match_pos_r < MAX_LEN &&
                store_q_r == char_r;

  always_comb begin
    best_nxt = best_r;
    if (match_pos_r != '0 && !lkpm_pkg::is_symbol(char_r) && cond_a_r) begin
      best_nxt = match_pos_r;
    end
    if (last_r && any_r && cond_b_r) begin
      best_nxt = match_pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alive_r     <= '1;
      count_r     <= '0;
      load_pos_r  <= '0;
      load_ovf_r  <= 1'b0;
      longest_r   <= '0;
      load_err_r  <= lkpm_pkg::STATUS_OK;
      match_pos_r <= '0;
      best_r      <= '0;
      dead_r      <= 1'b0;
      eval_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_acc && !res_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            char_r <= in_char;
            last_r <= in_data.last;
            unique case (in_data.command)
              lkpm_pkg::CMD_CLEAR: begin
                count_r     <= '0;
                load_pos_r  <= '0;
                load_ovf_r  <= 1'b0;
                longest_r   <= '0;
                load_err_r  <= lkpm_pkg::STATUS_OK;
                alive_r     <= '1;
                match_pos_r <= '0;
                best_r      <= '0;
                dead_r      <= 1'b0;
              end
              lkpm_pkg::CMD_LOAD: begin
                if (load_pos_r < MAX_LEN) begin
                  load_pos_r <= load_pos_r + 1'b1;
                end else begin
                  load_ovf_r <= 1'b1;
                end
                if (in_data.last) begin
                  load_pos_r <= '0;
                  load_ovf_r <= 1'b0;
                  if (load_ovf_r || load_pos_r >= MAX_LEN) begin
                    if (load_err_r != lkpm_pkg::STATUS_FULL) begin
                      load_err_r <= lkpm_pkg::STATUS_TOO_LONG;
                    end
                  end else if (count_r >= NUM_KW) begin
                    load_err_r <= lkpm_pkg::STATUS_FULL;
                  end else begin
                    alive_r[kw_widx] <= (match_pos_r == '0) && !dead_r;
                    count_r <= count_r + 1'b1;
                    if (commit_len > longest_r) begin
                      longest_r <= commit_len;
                    end
                  end
                end
              end
              lkpm_pkg::CMD_MATCH: begin
                issue_r  <= '0;
                cond_a_r <= 1'b0;
                cond_b_r <= 1'b0;
                any_r    <= 1'b0;
                state_r  <= dead_r ? S_FIN : S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          eval_v_r <= scan_rd;
          eval_k_r <= issue_r[KW-1:0];
          if (scan_rd) begin
            issue_r <= issue_r + 1'b1;
          end
          if (eval_v_r) begin
            if (alive_r[eval_k_r] && len_q_r == match_pos_r) begin
              cond_a_r <= 1'b1;
            end
            alive_r[eval_k_r] <= keep;
            if (keep) begin
              any_r <= 1'b1;
              if (len_q_r == match_pos_r + 1'b1) begin
                cond_b_r <= 1'b1;
              end
            end
          end
          if (!scan_rd && !eval_v_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last_r) begin
            if (!dead_r) begin
              best_r <= best_nxt;
              dead_r <= !any_r;
              if (match_pos_r < MAX_LEN) begin
                match_pos_r <= match_pos_r + 1'b1;
              end
            end
            state_r <= S_IDLE;
          end else if (res_load) begin
            out_valid_r           <= 1'b1;
            out_r.match_length    <= dead_r ? best_r : best_nxt;
            out_r.matched         <= (dead_r ? best_r : best_nxt) != '0;
            out_r.longest_keyword <= longest_r;
            out_r.status          <= load_err_r;
            alive_r     <= '1;
            match_pos_r <= '0;
            best_r      <= '0;
            dead_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NUM_KW) else $error("keyword count beyond table size");

  a_best_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= match_pos_r) else $error("best length ahead of match position");

  a_eval_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    eval_v_r |-> KCW'(eval_k_r) < count_r) else $error("scan beyond stored keywords");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN) else $error("result outside final state");

endmodule

/* dv/tb_longest_keyword_prefix_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_keyword_prefix_matcher
// Self-checking bench for the keyword table and longest-prefix match.
// ----------------------------------------------------------------------------
// Keyword tables are built from clear and load transfers, then match strings
// are fed with random idling on both channels. A behavioural copy of the
// table predicts each result and a scoreboard compares it field by field.
// ----------------------------------------------------------------------------
module tb_longest_keyword_prefix_matcher;

  localparam int NKW      = 256;
  localparam int MAXLEN   = 32;
  localparam int CYC_LIMIT = 4000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lkpm_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  lkpm_pkg::out_item_t out_data;

  int  cycles;
  int  n_items;
  bit  idle_on;

  // Predictor state
  logic [7:0] kw_chars[NKW][MAXLEN];
  int  kw_len[NKW];
  bit  kw_alive[NKW];
  int  kw_count, ld_pos, m_pos, best, long_len;
  bit  dead, ld_ovf;
  logic [1:0] ld_err;

  // Words used for well-formed strings
  byte words[$][$];

  longest_keyword_prefix_matcher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit sym_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit any_alive_len(int n);
    for (int k = 0; k < kw_count; k++)
      if (kw_alive[k] && kw_len[k] == n) return 1;
    return 0;
  endfunction

  function automatic void restart_search();
    for (int k = 0; k < NKW; k++) kw_alive[k] = 1;
    m_pos = 0;
    best  = 0;
    dead  = 0;
  endfunction

  // Advances the predictor by one accepted item; returns 1 with the result
  // when the item produces one.
  function automatic bit predict(lkpm_pkg::in_item_t it, output lkpm_pkg::out_item_t r);
    logic [7:0] c;
    bit survivor;
    r = '0;
    c = lower(it.character);
    if (it.command == lkpm_pkg::CMD_CLEAR) begin
      kw_count = 0; ld_pos = 0; ld_ovf = 0; long_len = 0; ld_err = lkpm_pkg::STATUS_OK;
      restart_search();
    end else if (it.command == lkpm_pkg::CMD_LOAD) begin
      if (ld_pos < MAXLEN) begin
        if (kw_count < NKW) kw_chars[kw_count][ld_pos] = c;
        ld_pos++;
      end else begin
        ld_ovf = 1;
      end
      if (it.last) begin
        if (ld_ovf) begin
          if (ld_err != lkpm_pkg::STATUS_FULL) ld_err = lkpm_pkg::STATUS_TOO_LONG;
        end else if (kw_count >= NKW) begin
          ld_err = lkpm_pkg::STATUS_FULL;
        end else begin
          kw_len[kw_count] = ld_pos;
          kw_alive[kw_count] = (m_pos == 0 && !dead);
          kw_count++;
          if (ld_pos > long_len) long_len = ld_pos;
        end
        ld_pos = 0;
        ld_ovf = 0;
      end
    end else if (it.command == lkpm_pkg::CMD_MATCH) begin
      if (!dead) begin
        if (m_pos > 0 && !sym_char(c) && any_alive_len(m_pos)) best = m_pos;
        survivor = 0;
        for (int k = 0; k < kw_count; k++) begin
          if (!kw_alive[k]) continue;
          if (kw_len[k] <= m_pos || m_pos >= MAXLEN || kw_chars[k][m_pos] != c)
            kw_alive[k] = 0;
          else
            survivor = 1;
        end
        if (!survivor) dead = 1;
        if (m_pos < MAXLEN) m_pos++;
        if (it.last && !dead && any_alive_len(m_pos)) best = m_pos;
      end
      if (it.last) begin
        r.matched = (best != 0);
        r.match_length = best[5:0];
        r.longest_keyword = long_len[5:0];
        r.status = ld_err;
        restart_search();
        return 1;
      end
    end
    return 0;
  endfunction

  class match_scoreboard;
    lkpm_pkg::out_item_t pending[$];
    int        errors;

    function void note_input(lkpm_pkg::in_item_t it);
      lkpm_pkg::out_item_t r;
      if (predict(it, r)) pending.insert(pending.size(), r);
    endfunction

    function void check_result(lkpm_pkg::out_item_t got);
      lkpm_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d, actual %0d", want.matched, got.matched);
        errors++;
      end
      if (got.match_length !== want.match_length) begin
        $error("match_length: expected %0d, actual %0d", want.match_length,
               got.match_length);
        errors++;
      end
      if (got.longest_keyword !== want.longest_keyword) begin
        $error("longest_keyword: expected %0d, actual %0d", want.longest_keyword,
               got.longest_keyword);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  match_scoreboard sb;

  task automatic send(logic [1:0] cmd, logic [7:0] ch, logic l);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, character: ch, last: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(in_data);
    n_items++;
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || in_stall) @(posedge clk);
  endtask

  // Randomly turn lowercase letters to uppercase
  function automatic logic [7:0] mix_case(byte b);
    if (b >= "a" && b <= "z" && $urandom_range(0, 1)) return b - 8'd32;
    return b;
  endfunction

  task automatic load_word(byte w[$]);
    for (int i = 0; i < w.size(); i++)
      send(lkpm_pkg::CMD_LOAD, mix_case(w[i]), i == w.size() - 1);
  endtask

  task automatic match_str(byte s[$]);
    for (int i = 0; i < s.size(); i++)
      send(lkpm_pkg::CMD_MATCH, mix_case(s[i]), i == s.size() - 1);
  endtask

  function automatic byte sym_byte();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return byte'($urandom_range("0", "9"));
    if (r == 1) return "_";
    return byte'($urandom_range("a", "d"));
  endfunction

  function automatic void make_words(int n);
    byte w[$];
    words.delete();
    for (int i = 0; i < n; i++) begin
      w.delete();
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? MAXLEN : 5))
        w.insert(w.size(), sym_byte());
      words.insert(words.size(), w);
    end
  endfunction

  task automatic random_string();
    byte s[$];
    byte w[$];
    int  r;
    r = $urandom_range(0, 9);
    if (r < 7 && words.size() > 0) begin
      w = words[$urandom_range(0, words.size() - 1)];
      s = w;
      if ($urandom_range(0, 2) != 0 && s.size() > 1 && r < 2)
        s = s[0:$urandom_range(0, s.size() - 2)];
      case ($urandom_range(0, 3))
        0: ;
        1: s.insert(s.size(), byte'($urandom_range(0, 47)));
        2: s.insert(s.size(), sym_byte());
        default: begin
          s.insert(s.size(), " ");
          repeat ($urandom_range(0, 3)) s.insert(s.size(), byte'($urandom_range(0, 255)));
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) s.insert(s.size(), byte'($urandom_range(0, 255)));
    end
    match_str(s);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    byte w[$];
    bit  first_tbl;
    sb = new();
    n_items = 0;
    first_tbl = 1'b1;
    idle_on = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    kw_count = 0; ld_pos = 0; ld_ovf = 0; long_len = 0; ld_err = lkpm_pkg::STATUS_OK;
    restart_search();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, mixed case, boundary, overlong, byte zero,
    // ignored command
    match_str('{"a"});
    send(lkpm_pkg::CMD_LOAD, "I", 1'b0);
    send(lkpm_pkg::CMD_LOAD, "f", 1'b1);
    send(lkpm_pkg::CMD_IGNORED, 8'hFF, 1'b1);
    match_str('{"i", "F", " ", "x"});
    match_str('{"i", "f", "x"});
    match_str('{"I", "f"});
    match_str('{"i", "f", 8'h00});
    send(lkpm_pkg::CMD_MATCH, "i", 1'b0);
    load_word('{"i"});          // committed mid-string: not a candidate
    send(lkpm_pkg::CMD_MATCH, "(", 1'b1);
    for (int i = 0; i < MAXLEN; i++) w.insert(w.size(), "z");
    load_word(w);
    w.insert(w.size(), "z");
    match_str(w);
    load_word(w);               // overlong
    match_str('{"z", 8'hFF});
    send(lkpm_pkg::CMD_CLEAR, 8'h00, 1'b0);
    send(lkpm_pkg::CMD_MATCH, "q", 1'b1);

    // Table full
    for (int k = 0; k <= NKW; k++)
      send(lkpm_pkg::CMD_LOAD, 8'($urandom_range(0, 255)), 1'b1);
    match_str('{8'h80, "!"});
    go_quiet();                 // sender holds off until all results are back

    while (n_items < 1440) begin
      if ($urandom_range(0, 7) == 0 || first_tbl) begin
        first_tbl = 1'b0;
        send(lkpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        make_words($urandom_range(1, 12));
        foreach (words[i]) load_word(words[i]);
      end
      if (n_items > 1150) idle_on = 1'b0;
      random_string();
    end

    go_quiet();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
